@@ rtl/error_diffusion_color_reducer_assert.svh @@
// assertion helpers for the rtl
`ifndef ERROR_DIFFUSION_COLOR_REDUCER_ASSERT_SVH
`define ERROR_DIFFUSION_COLOR_REDUCER_ASSERT_SVH

// property must hold at every rising clock edge outside reset
`define EDCR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define EDCR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/edcr_pkg.sv @@
package edcr_pkg;

  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CH_N       = 3;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned DATA_W     = CH_N * CH_W;
  localparam int unsigned ERR_W      = 7;
  localparam int unsigned FW_W       = 13;
  localparam int unsigned FH_W       = 16;
  localparam int unsigned CB_W       = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OQ_DEPTH   = 4;
  localparam int unsigned OQ_PTR_W   = 2;
  localparam int unsigned OQ_CNT_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BITS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 2'd3;

  typedef struct packed {
    logic [FH_W-1:0] h_last;
    logic [2:0]      shift;
    logic            dither;
  } cfg_t;

  function automatic logic [CH_W-1:0] sat3(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b,
                                           input logic [CH_W-1:0] c);
    logic [CH_W+1:0] s;
    s = (CH_W+2)'(a) + (CH_W+2)'(b) + (CH_W+2)'(c);
    return (s > (CH_W+2)'(255)) ? {CH_W{1'b1}} : s[CH_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] add_sat24(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int c = 0; c < CH_N; c++) begin
      r[c*CH_W +: CH_W] = sat3(a[c*CH_W +: CH_W], b[c*CH_W +: CH_W], '0);
    end
    return r;
  endfunction

endpackage

@@ rtl/edcr_if.sv @@
interface edcr_in_if;
  logic                          valid;
  logic                          ready;
  logic [edcr_pkg::PIX_W-1:0]    in_pixel;
  modport source (output valid, output in_pixel, input ready);
  modport sink   (input valid, input in_pixel, output ready);
endinterface

interface edcr_out_if;
  logic                          valid;
  logic                          ready;
  logic [edcr_pkg::PIX_W-1:0]    out_pixel;
  modport source (output valid, output out_pixel, input ready);
  modport sink   (input valid, input out_pixel, output ready);
endinterface

interface edcr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [edcr_pkg::CFG_IDX_W-1:0]    index;
  logic [edcr_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/edcr_ram.sv @@
module edcr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/edcr_cfg.sv @@
module edcr_cfg #(
  parameter int unsigned MAX_WIDTH = 4096,
  localparam int unsigned AW       = $clog2(MAX_WIDTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  edcr_cfg_if.sink             cfg_i,
  output logic [AW-1:0]        w_last_o,
  output edcr_pkg::cfg_t       cfg_o
);

  localparam int unsigned W_RST = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;

  logic [AW-1:0]                 w_last_q, w_last_d;
  logic [edcr_pkg::FH_W-1:0]     h_last_q, h_last_d;
  logic [2:0]                    shift_q, shift_d;
  logic                          dither_q;
  logic [edcr_pkg::FW_W-1:0]     fw;
  logic [edcr_pkg::FH_W-1:0]     fh;
  logic [edcr_pkg::CB_W-1:0]     cb, kept, sh;

  assign cfg_i.ready = 1'b1;

  // registers hold the clamped form that the datapath uses
  always_comb begin
    fw = cfg_i.data[edcr_pkg::FW_W-1:0];
    fh = cfg_i.data[edcr_pkg::FH_W-1:0];
    cb = cfg_i.data[edcr_pkg::CB_W-1:0];
    if (fw == '0) begin
      w_last_d = '0;
    end else if (32'(fw) > MAX_WIDTH) begin
      w_last_d = AW'(MAX_WIDTH - 1);
    end else begin
      w_last_d = AW'(fw - edcr_pkg::FW_W'(1));
    end
    h_last_d = (fh == '0) ? '0 : fh - edcr_pkg::FH_W'(1);
    if (cb == '0) begin
      kept = edcr_pkg::CB_W'(1);
    end else if (cb > edcr_pkg::CB_W'(8)) begin
      kept = edcr_pkg::CB_W'(8);
    end else begin
      kept = cb;
    end
    sh      = edcr_pkg::CB_W'(8) - kept;
    shift_d = sh[2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= AW'(W_RST - 1);
      h_last_q <= edcr_pkg::FH_W'(479);
      shift_q  <= '0;
      dither_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        edcr_pkg::REG_FRAME_WIDTH:   w_last_q <= w_last_d;
        edcr_pkg::REG_FRAME_HEIGHT:  h_last_q <= h_last_d;
        edcr_pkg::REG_COLOR_BITS:    shift_q  <= shift_d;
        edcr_pkg::REG_DITHER_ENABLE: dither_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign w_last_o     = w_last_q;
  assign cfg_o.h_last = h_last_q;
  assign cfg_o.shift  = shift_q;
  assign cfg_o.dither = dither_q;

endmodule

@@ rtl/edcr_pipe.sv @@
`include "error_diffusion_color_reducer_assert.svh"

module edcr_pipe #(
  parameter int unsigned MAX_WIDTH = 4096,
  localparam int unsigned AW       = $clog2(MAX_WIDTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  edcr_in_if.sink                           in_i,
  input  logic [AW-1:0]                     w_last_i,
  input  edcr_pkg::cfg_t                    cfg_i,
  input  logic [edcr_pkg::OQ_CNT_W-1:0]     q_cnt_i,
  output logic                              push_o,
  output logic [edcr_pkg::PIX_W-1:0]        push_data_o
);

  localparam int unsigned DW   = edcr_pkg::DATA_W;
  localparam int unsigned CH_N = edcr_pkg::CH_N;
  localparam int unsigned CW   = edcr_pkg::CH_W;
  localparam int unsigned EW   = edcr_pkg::ERR_W;
  localparam int unsigned HW   = edcr_pkg::FH_W;
  localparam int unsigned QW   = edcr_pkg::OQ_CNT_W;

  typedef struct packed {
    logic [edcr_pkg::PIX_W-1:0] pixel;
    logic [AW-1:0]              col;
    logic                       last_col;
    logic                       last_row;
    logic                       row_zero;
  } s1_t;

  typedef struct packed {
    logic [edcr_pkg::PIX_W-1:0] result;
    logic [AW-1:0]              col;
    logic                       last_col;
    logic                       last_row;
    logic [CH_N-1:0][EW-1:0]    err;
  } s2_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [DW-1:0] data;
  } wr_t;

  // clearing pass
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  // raster position
  logic [AW-1:0] col_cnt_q, col_cnt_d, col0;
  logic [HW-1:0] row_cnt_q, row_cnt_d, row0;
  logic          last_col0, last_row0, w_small, in_ready, in_acc;
  logic [QW-1:0] inflight;

  // stage 1
  logic          s1_valid_q;
  s1_t           s1_q;
  logic [DW-1:0] rdata, above, rc_q, rc_d, s7;
  logic [CH_N-1:0][CW-1:0] p, q;
  logic [CH_N-1:0][EW-1:0] err;
  logic [CH_N-1:0][CW-1:0] e8;
  logic [CH_N-1:0][9:0]    t7;
  logic [CW-1:0]           mask;
  logic [edcr_pkg::PIX_W-1:0] result;

  // stage 2
  logic          s2_valid_q;
  s2_t           s2_q;
  logic [CH_N-1:0][9:0] t3, t5;
  logic [DW-1:0] sh3, sh5, sh1, wr_prev, here;
  logic [DW-1:0] pend_prev_q, pend_prev_d, pend_cur_q, pend_cur_d;
  logic          dfr_valid_q, dfr_valid_d, dfr_set, dfr_flush;
  logic [AW-1:0] dfr_addr_q;
  logic [DW-1:0] dfr_data_q;
  wr_t           wr, fwd_q;

  // ---------------------------------------------------------------- stage 0
  always_comb begin
    col0      = (col_cnt_q > w_last_i) ? w_last_i : col_cnt_q;
    row0      = (row_cnt_q > cfg_i.h_last) ? cfg_i.h_last : row_cnt_q;
    last_col0 = (col0 == w_last_i);
    last_row0 = (row0 == cfg_i.h_last);
    w_small   = (w_last_i <= AW'(1));
    inflight  = QW'(s1_valid_q) + QW'(s2_valid_q) + q_cnt_i;
    // tiny rows read what the previous pixel writes, so wait for it to land
    in_ready  = !clr_busy_q && (inflight < QW'(edcr_pkg::OQ_DEPTH)) &&
                (!w_small || (!s1_valid_q && !s2_valid_q && !dfr_valid_q));
    in_acc    = in_i.valid && in_ready;
    if (last_col0) begin
      col_cnt_d = '0;
      row_cnt_d = last_row0 ? '0 : row0 + HW'(1);
    end else begin
      col_cnt_d = col0 + AW'(1);
      row_cnt_d = row_cnt_q;
    end
  end

  assign in_i.ready = in_ready;

  edcr_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (in_acc),
    .raddr_i (col0),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    // the write that landed at the read edge is not in the read data yet
    if (fwd_q.en && (fwd_q.addr == s1_q.col)) begin
      above = fwd_q.data;
    end else begin
      above = rdata;
    end
    if (s1_q.row_zero) begin
      above = '0;
    end
    mask = {CW{1'b1}} << cfg_i.shift;
    for (int c = 0; c < CH_N; c++) begin
      if (cfg_i.dither) begin
        p[c] = edcr_pkg::sat3(s1_q.pixel[c*CW +: CW], above[c*CW +: CW],
                              rc_q[c*CW +: CW]);
      end else begin
        p[c] = s1_q.pixel[c*CW +: CW];
      end
      q[c]   = p[c] & mask;
      e8[c]  = p[c] - q[c];
      err[c] = cfg_i.dither ? e8[c][EW-1:0] : '0;
      t7[c]  = 10'(err[c]) * 10'd7;
      s7[c*CW +: CW] = CW'(t7[c][9:4]);
    end
    result = {s1_q.pixel[edcr_pkg::PIX_W-1:DW], q[2], q[1], q[0]};
    rc_d   = rc_q;
    if (s1_valid_q) begin
      rc_d = s1_q.last_col ? '0 : s7;
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      t3[c] = 10'(s2_q.err[c]) * 10'd3;
      t5[c] = 10'(s2_q.err[c]) * 10'd5;
      sh3[c*CW +: CW] = CW'(t3[c][9:4]);
      sh5[c*CW +: CW] = CW'(t5[c][9:4]);
      sh1[c*CW +: CW] = CW'(s2_q.err[c][EW-1:4]);
    end
    // nothing goes below the last row
    if (s2_q.last_row) begin
      sh3 = '0;
      sh5 = '0;
      sh1 = '0;
    end
    wr_prev = edcr_pkg::add_sat24(pend_prev_q, sh3);
    here    = edcr_pkg::add_sat24(pend_cur_q, sh5);

    pend_prev_d = pend_prev_q;
    pend_cur_d  = pend_cur_q;
    if (s2_valid_q) begin
      if (s2_q.last_col) begin
        pend_prev_d = '0;
        pend_cur_d  = '0;
      end else begin
        pend_prev_d = here;
        pend_cur_d  = sh1;
      end
    end

    // one write port: the end-of-row entry waits for the next free slot
    dfr_set   = s2_valid_q && s2_q.last_col && (s2_q.col != '0);
    dfr_flush = 1'b0;
    wr        = '0;
    if (clr_busy_q) begin
      wr.en   = 1'b1;
      wr.addr = clr_addr_q;
      wr.data = '0;
    end else if (s2_valid_q && (s2_q.col != '0)) begin
      wr.en   = 1'b1;
      wr.addr = s2_q.col - AW'(1);
      wr.data = wr_prev;
    end else if (s2_valid_q && s2_q.last_col) begin
      wr.en   = 1'b1;
      wr.addr = s2_q.col;
      wr.data = here;
    end else if (dfr_valid_q) begin
      wr.en     = 1'b1;
      wr.addr   = dfr_addr_q;
      wr.data   = dfr_data_q;
      dfr_flush = 1'b1;
    end
    dfr_valid_d = dfr_set || (dfr_valid_q && !dfr_flush);
  end

  assign push_o      = s2_valid_q;
  assign push_data_o = s2_q.result;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      rc_q        <= '0;
      pend_prev_q <= '0;
      pend_cur_q  <= '0;
      dfr_valid_q <= 1'b0;
      fwd_q       <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_acc) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
      end
      s1_valid_q  <= in_acc;
      s2_valid_q  <= s1_valid_q;
      rc_q        <= rc_d;
      pend_prev_q <= pend_prev_d;
      pend_cur_q  <= pend_cur_d;
      dfr_valid_q <= dfr_valid_d;
      fwd_q       <= wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.pixel    <= in_i.in_pixel;
      s1_q.col      <= col0;
      s1_q.last_col <= last_col0;
      s1_q.last_row <= last_row0;
      s1_q.row_zero <= (row0 == '0);
    end
    if (s1_valid_q) begin
      s2_q.result   <= result;
      s2_q.col      <= s1_q.col;
      s2_q.last_col <= s1_q.last_col;
      s2_q.last_row <= s1_q.last_row;
      s2_q.err      <= err;
    end
    if (dfr_set) begin
      dfr_addr_q <= s2_q.col;
      dfr_data_q <= here;
    end
  end

  // ---------------------------------------------------------------- checks
  `EDCR_ASSERT(a_dfr_kept, clk_i, rst_ni, dfr_set |-> (!dfr_valid_q || dfr_flush), "end-of-row write lost")
  `EDCR_ASSERT_NEVER(a_clr_alone, clk_i, rst_ni, clr_busy_q && (s1_valid_q || s2_valid_q), "pixel in flight during clearing")
  `EDCR_ASSERT(a_two_stages, clk_i, rst_ni, in_acc |-> ##2 s2_valid_q, "accepted pixel did not reach stage two")
  `EDCR_ASSERT_NEVER(a_q_room, clk_i, rst_ni, inflight > QW'(edcr_pkg::OQ_DEPTH), "more pixels in flight than queue room")

endmodule

@@ rtl/edcr_outq.sv @@
module edcr_outq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic [edcr_pkg::PIX_W-1:0]      push_data_i,
  edcr_out_if.source                      out_o,
  output logic [edcr_pkg::OQ_CNT_W-1:0]   cnt_o
);

  localparam int unsigned PW = edcr_pkg::OQ_PTR_W;
  localparam int unsigned QW = edcr_pkg::OQ_CNT_W;

  logic [edcr_pkg::OQ_DEPTH-1:0][edcr_pkg::PIX_W-1:0] fifo_q;
  logic [PW-1:0] head_q, tail_q;
  logic [QW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign out_o.valid     = (cnt_q != '0);
  assign out_o.out_pixel = fifo_q[head_q];
  assign pop             = out_o.valid && out_o.ready;
  assign cnt_d           = cnt_q + QW'(push_i) - QW'(pop);
  assign cnt_o           = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        tail_q <= tail_q + PW'(1);
      end
      if (pop) begin
        head_q <= head_q + PW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[tail_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/error_diffusion_color_reducer.sv @@
// an accepted pixel passes the stage 1 and stage 2 registers and the output queue before it is valid on out_o
// throughput: one pixel per cycle while the output queue has room, set by the registered error and right-share loop
// rows of one or two pixels: a new pixel is taken only after the last one and its line store write-back are done
// reset: after rst_ni rises the line store is cleared, with in_i not ready until every entry is cleared
// reset: registers return to 640 (or MAX_WIDTH if smaller) x 480, 8 bits per channel, dither off, position zero
module error_diffusion_color_reducer #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  edcr_cfg_if.sink    cfg_i,
  edcr_in_if.sink     in_i,
  edcr_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic [AW-1:0]                     w_last;
  edcr_pkg::cfg_t                    cfg;
  logic                              push;
  logic [edcr_pkg::PIX_W-1:0]        push_data;
  logic [edcr_pkg::OQ_CNT_W-1:0]     q_cnt;

  edcr_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .w_last_o (w_last),
    .cfg_o    (cfg)
  );

  edcr_pipe #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .w_last_i    (w_last),
    .cfg_i       (cfg),
    .q_cnt_i     (q_cnt),
    .push_o      (push),
    .push_data_o (push_data)
  );

  edcr_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .out_o       (out_o),
    .cnt_o       (q_cnt)
  );

endmodule
